// ===== rtl/nsr_pkg.sv =====
// Shared widths, command bundle and controller states for the square root unit.
package nsr_pkg;

    localparam int RAD_W  = 32;               // radicand, unsigned Q16.16
    localparam int FRAC_W = 16;               // extra fraction bits for a Q8.16 root
    localparam int WIDE_W = RAD_W + FRAC_W;   // widened radicand
    localparam int ROOT_W = WIDE_W / 2;       // one root bit per step
    localparam int REM_W  = ROOT_W + 2;       // partial remainder
    localparam int CNT_W  = $clog2(ROOT_W);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

    typedef struct packed {
        logic load;      // capture a new radicand, clear the recurrence
        logic step;      // settle one root bit
        logic publish;   // copy the finished root into the output register
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

// ===== rtl/nsr_ctrl.sv =====
// Sequencer for the square root unit: handshakes, step counter, output valid.
module nsr_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           radicand_valid,
    output logic           radicand_ready,
    output logic           root_valid,
    input  logic           root_ready,
    output nsr_pkg::cmd_t  cmd
);

    nsr_pkg::state_t               state_reg, state_next;
    logic [nsr_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          slot_free;

    assign radicand_ready = (state_reg == nsr_pkg::ST_IDLE);
    assign root_valid     = out_valid_reg;
    assign slot_free      = !out_valid_reg || root_ready;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        unique case (state_reg)
            nsr_pkg::ST_IDLE:
            begin
                if (radicand_valid)
                begin
                    cmd.load   = 1'b1;
                    count_next = '0;
                    state_next = nsr_pkg::ST_RUN;
                end
            end
            nsr_pkg::ST_RUN:
            begin
                cmd.step   = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == nsr_pkg::LAST_STEP)
                begin
                    state_next = nsr_pkg::ST_FINISH;
                end
            end
            nsr_pkg::ST_FINISH:
            begin
                // hold the result until the output register is free
                if (slot_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = nsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nsr_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !root_ready) || cmd.publish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nsr_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/nsr_datapath.sv =====
// Restoring digit recurrence for the root, one bit per step, plus output register.
module nsr_datapath
(
    input  logic                         clk,
    input  nsr_pkg::cmd_t                cmd,
    input  logic [nsr_pkg::RAD_W-1:0]    radicand,
    output logic [nsr_pkg::ROOT_W-1:0]   root
);

    logic [nsr_pkg::WIDE_W-1:0] wide_reg, wide_next;
    logic [nsr_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [nsr_pkg::ROOT_W-1:0] q_reg, q_next;
    logic [nsr_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [nsr_pkg::REM_W+1:0]  cur;
    logic [nsr_pkg::REM_W+1:0]  trial;
    logic [nsr_pkg::REM_W+1:0]  diff;
    logic                       fits;

    // bring down the next two radicand bits and try the root bit as one
    assign cur   = {rem_reg, wide_reg[nsr_pkg::WIDE_W-1 -: 2]};
    assign trial = {2'b00, q_reg, 2'b01};
    assign diff  = cur - trial;
    assign fits  = (cur >= trial);

    always_comb
    begin
        wide_next = wide_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        root_next = root_reg;
        if (cmd.load)
        begin
            wide_next = {radicand, {nsr_pkg::FRAC_W{1'b0}}};
            rem_next  = '0;
            q_next    = '0;
        end
        else if (cmd.step)
        begin
            wide_next = {wide_reg[nsr_pkg::WIDE_W-3:0], 2'b00};
            rem_next  = fits ? diff[nsr_pkg::REM_W-1:0] : cur[nsr_pkg::REM_W-1:0];
            q_next    = {q_reg[nsr_pkg::ROOT_W-2:0], fits};
        end
        if (cmd.publish)
        begin
            root_next = q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wide_reg <= wide_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule

// ===== rtl/newton_square_root_top.sv =====
// Top level of the fixed-point square root unit: controller plus datapath.
//
// Usage: a request on the radicand channel (radicand_valid/radicand_ready)
// carries one unsigned Q16.16 value. The unit returns its truncated square
// root in unsigned Q8.16 on the root channel (root_valid/root_ready): the
// largest r with r*r <= radicand * 2^16. A zero radicand gives zero.
//
// The root bits are settled by a restoring digit recurrence in the
// datapath, one bit per cycle for all 24 bits, followed by a publish
// step that moves the root into the output register once it is free;
// the registered root_valid rises after that publish. A new request is
// taken only after the previous root has been published, since the
// sequencer accepts only while idle, not during the recurrence or publish.
//
// The output register lets a new request start while an earlier root still
// waits to be taken. If the receiver stalls, the finished root is held in
// the datapath until the output register frees up, and no new request is
// taken meanwhile. Reset (rst_n low, asynchronous) returns the sequencer to
// idle and drops any pending result; the datapath registers are not reset.
module newton_square_root_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         radicand_valid,
    output logic                         radicand_ready,
    input  logic [nsr_pkg::RAD_W-1:0]    radicand,
    output logic                         root_valid,
    input  logic                         root_ready,
    output logic [nsr_pkg::ROOT_W-1:0]   root
);

    nsr_pkg::cmd_t cmd;

    // sequencer: decides when to load, step and publish
    nsr_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .radicand_valid (radicand_valid),
        .radicand_ready (radicand_ready),
        .root_valid     (root_valid),
        .root_ready     (root_ready),
        .cmd            (cmd)
    );

    // recurrence registers and output register
    nsr_datapath u_datapath
    (
        .clk      (clk),
        .cmd      (cmd),
        .radicand (radicand),
        .root     (root)
    );

endmodule

// ===== rtl/nsr_checker.sv =====
// Port-level checks for the square root unit and their binding to the top level.
module nsr_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         radicand_valid,
    input  logic                         radicand_ready,
    input  logic [nsr_pkg::RAD_W-1:0]    radicand,
    input  logic                         root_valid,
    input  logic                         root_ready,
    input  logic [nsr_pkg::ROOT_W-1:0]   root
);

    // a pending root holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && !root_ready |=> root_valid && $stable(root))
        else $error("root dropped or changed while stalled");

    // a waiting request holds its value until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        radicand_valid && !radicand_ready |=> radicand_valid && $stable(radicand))
        else $error("request dropped or changed while waiting");

    // a taken request blocks new requests for the whole recurrence
    assert property (@(posedge clk) disable iff (!rst_n)
        radicand_valid && radicand_ready |=> !radicand_ready)
        else $error("request accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        radicand_valid && radicand_ready |-> ##24 !radicand_ready)
        else $error("recurrence finished early");

    // a new root appears only out of the busy phase
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(root_valid) |-> !$past(radicand_ready))
        else $error("root appeared without a request in progress");

endmodule

bind newton_square_root_top nsr_checker u_nsr_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .radicand_valid (radicand_valid),
    .radicand_ready (radicand_ready),
    .radicand       (radicand),
    .root_valid     (root_valid),
    .root_ready     (root_ready),
    .root           (root)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the fixed-point square root unit.
`timescale 1ns / 100ps

module tb;

    localparam int RAD_W  = nsr_pkg::RAD_W;
    localparam int ROOT_W = nsr_pkg::ROOT_W;

    // Directed row: a radicand and, where it is obvious, the root typed in.
    typedef struct packed {
        logic [RAD_W-1:0]  value;
        logic              known;
        logic [ROOT_W-1:0] root;
    } stim_row_t;

    // One outstanding root, kept with the radicand that caused it.
    typedef struct packed {
        logic [RAD_W-1:0]  radicand;
        logic [ROOT_W-1:0] root;
    } root_expect_t;

    localparam int DIRECTED_ROWS = 18;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              radicand_valid = 1'b0;
    logic              radicand_ready;
    logic [RAD_W-1:0]  radicand = '0;
    logic              root_valid;
    logic              root_ready = 1'b0;
    logic [ROOT_W-1:0] root;

    root_expect_t pending_roots[$];
    stim_row_t    directed_rows [DIRECTED_ROWS];
    int           mismatch_count = 0;
    int           burst_left = 0;

    newton_square_root_top u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .radicand_valid (radicand_valid),
        .radicand_ready (radicand_ready),
        .radicand       (radicand),
        .root_valid     (root_valid),
        .root_ready     (root_ready),
        .root           (root)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run (about 1.5 ms).
    initial
    begin
        #8ms;
        $display("%0t: timeout with %0d roots outstanding", $time, pending_roots.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Floor square root of radicand * 2^16, one root bit per pass,
    // most significant bit first. Zero falls out as zero.
    function automatic logic [ROOT_W-1:0] floor_root_q816(input logic [RAD_W-1:0] value);
        logic [49:0] rest;
        logic [49:0] acc;
        logic [49:0] probe;
        rest  = {2'b00, value, 16'h0000};
        acc   = '0;
        probe = 50'd1 << (2 * ROOT_W - 2);
        for (int i = 0; i < ROOT_W; i++)
        begin
            if (rest >= acc + probe)
            begin
                rest = rest - (acc + probe);
                acc  = (acc >> 1) + probe;
            end
            else
            begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        return acc[ROOT_W-1:0];
    endfunction

    // Offer one request and hold it until it is taken. Pace the sender in
    // bursts: at the end of a burst drop valid for a random gap first.
    task automatic offer_radicand(input logic [RAD_W-1:0] value, input logic known,
                                  input logic [ROOT_W-1:0] known_root);
        root_expect_t entry;
        if (burst_left == 0)
        begin
            radicand_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        radicand_valid <= 1'b1;
        radicand       <= value;
        do @(posedge clk); while (!radicand_ready);
        burst_left--;
        entry.radicand = value;
        entry.root     = known ? known_root : floor_root_q816(value);
        pending_roots.push_back(entry);
    endtask

    // Drop valid and hold off until every outstanding root has come back.
    task automatic drain_roots();
        radicand_valid <= 1'b0;
        do @(posedge clk); while (pending_roots.size() != 0);
        burst_left = 0;
    endtask

    // Receiver: check each taken root, then pick the next ready level.
    // The stall pattern cycles through four modes in turn:
    // always ready, coin flip, long stalls, and rare random stalls.
    int ready_cycle = 0;
    int hold_left   = 0;

    always @(posedge clk)
    begin
        root_expect_t head;
        if (rst_n && root_valid && root_ready)
        begin
            if (pending_roots.size() == 0)
            begin
                $display("%0t: unexpected root: expected none, got %h", $time, root);
                mismatch_count++;
            end
            else
            begin
                head = pending_roots.pop_front();
                if (root !== head.root)
                begin
                    $display("%0t: root mismatch for radicand %h: expected %h, got %h",
                             $time, head.radicand, head.root, root);
                    mismatch_count++;
                end
            end
        end
        ready_cycle++;
        case (ready_cycle[9:8])
            2'd0: root_ready <= 1'b1;
            2'd1: root_ready <= 1'($urandom_range(0, 1));
            2'd2:
            begin
                if (hold_left != 0)
                begin
                    hold_left--;
                    root_ready <= 1'b0;
                end
                else
                begin
                    root_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        hold_left = $urandom_range(1, 40);
                end
            end
            default: root_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Main stimulus.
    initial
    begin
        logic [RAD_W-1:0]  value;
        logic [ROOT_W-1:0] r;
        logic [47:0]       square;

        // Directed rows: zero, both extremes, exact squares, values just
        // below an exact square (where a naive Newton loop would hunt), and
        // alternating bit patterns. Obvious roots are typed in.
        directed_rows = '{
            '{32'h0000_0000, 1'b1, 24'h00_0000},   // zero radicand gives zero
            '{32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF},   // largest radicand
            '{32'h0001_0000, 1'b1, 24'h01_0000},   // 1.0
            '{32'h0004_0000, 1'b1, 24'h02_0000},   // 4.0
            '{32'h0064_0000, 1'b1, 24'h0A_0000},   // 100.0
            '{32'h0000_4000, 1'b1, 24'h00_8000},   // 0.25
            '{32'h0000_0001, 1'b1, 24'h00_0100},   // smallest nonzero
            '{32'h0000_0004, 1'b1, 24'h00_0200},
            '{32'hFFFE_0001, 1'b1, 24'hFF_FF00},   // exact square near the top
            '{32'hFFFE_0000, 1'b0, 24'h00_0000},   // just below it
            '{32'h0000_0002, 1'b0, 24'h00_0000},
            '{32'h0000_0003, 1'b0, 24'h00_0000},
            '{32'h0000_8000, 1'b0, 24'h00_0000},   // 0.5
            '{32'h8000_0000, 1'b0, 24'h00_0000},
            '{32'h7FFF_FFFF, 1'b0, 24'h00_0000},
            '{32'hAAAA_AAAA, 1'b0, 24'h00_0000},
            '{32'h5555_5555, 1'b0, 24'h00_0000},
            '{32'h0003_FFFF, 1'b0, 24'h00_0000}    // just below 4.0
        };

        // Hold reset, then release it for good.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_radicand(directed_rows[i].value, directed_rows[i].known,
                           directed_rows[i].root);

        // Let the unit run dry once before the random part.
        drain_roots();

        for (int n = 0; n < 1600; n++)
        begin
            case ($urandom_range(0, 5))
                0, 5: value = $urandom;
                // small magnitudes, down to a single low bit
                1: value = $urandom & (32'hFFFF_FFFF >> $urandom_range(0, 31));
                // straddle a root boundary: smallest radicand with root at least r, or one less
                2:
                begin
                    r      = 24'($urandom_range(0, 24'hFF_FFFF));
                    square = 48'(r) * 48'(r);
                    value  = 32'((square + 48'h0_FFFF) >> 16);
                    if (value != 0 && $urandom_range(0, 1) == 1)
                        value = value - 1;
                end
                // exact squares
                3:
                begin
                    value = $urandom_range(0, 16'hFFFF);
                    value = value * value;
                end
                // crowd the top of the range
                default: value = 32'hFFFF_FFFF - $urandom_range(0, 255);
            endcase
            offer_radicand(value, 1'b0, '0);
            if (n % 400 == 399)
                drain_roots();
        end

        // Wait out the stragglers, then wait longer than one full request takes,
        // so that any stray result can show.
        drain_roots();
        repeat (60) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
